// ===== rtl/rlp_pkg.sv =====
// Package: types, codes and constants shared by the radio link pairing controller.
package rlp_pkg;

    localparam int TIMER_BITS_DEF = 17;
    localparam int CFG_DATA_W     = 16;
    localparam int CFG_INDEX_W    = 3;
    localparam int QDEPTH         = 2;
    localparam int QAW            = $clog2(QDEPTH);
    localparam int QCW            = $clog2(QDEPTH + 1);

    localparam logic [1:0] ACT_TICK   = 2'd0;
    localparam logic [1:0] ACT_PKT    = 2'd1;
    localparam logic [1:0] ACT_UNPAIR = 2'd2;
    localparam logic [1:0] ACT_NONE   = 2'd3;

    localparam logic [1:0] MODE_HUNT = 2'd0;
    localparam logic [1:0] MODE_PAIR = 2'd1;
    localparam logic [1:0] MODE_LINK = 2'd2;

    localparam logic [1:0] CAUSE_NONE    = 2'd0;
    localparam logic [1:0] CAUSE_TIMEOUT = 2'd1;
    localparam logic [1:0] CAUSE_SILENT  = 2'd2;
    localparam logic [1:0] CAUSE_UNPAIR  = 2'd3;

    localparam logic [CFG_INDEX_W-1:0] REG_HOP_PERIOD  = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] REG_REQ_PERIOD  = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] REG_PAIR_WAIT   = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] REG_SILENCE     = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] REG_FIRST_CH    = 3'd4;
    localparam logic [CFG_INDEX_W-1:0] REG_LAST_CH     = 3'd5;
    localparam logic [CFG_INDEX_W-1:0] REG_MAX_LEN     = 3'd6;

    localparam logic [15:0] RST_HOP_PERIOD = 16'd250;
    localparam logic [15:0] RST_REQ_PERIOD = 16'd1000;
    localparam logic [15:0] RST_PAIR_WAIT  = 16'd30000;
    localparam logic [15:0] RST_SILENCE    = 16'd5000;
    localparam logic [3:0]  RST_FIRST_CH   = 4'd1;
    localparam logic [3:0]  RST_LAST_CH    = 4'd13;
    localparam logic [7:0]  RST_MAX_LEN    = 8'd250;

    localparam logic [7:0] CH_BRACE = 8'h7B;
    localparam logic [7:0] CH_QUOTE = 8'h22;
    localparam logic [7:0] CH_H     = 8'h68;
    localparam logic [7:0] CH_B     = 8'h62;
    localparam logic [7:0] CH_P     = 8'h70;
    localparam logic [7:0] CH_A     = 8'h61;
    localparam logic [7:0] HEAD_LEN = 8'd5;

    typedef struct packed {
        logic [1:0]  action;
        logic [47:0] src_mac;
        logic [7:0]  pkt_len;
        logic [7:0]  byte_0;
        logic [7:0]  byte_1;
        logic [7:0]  byte_2;
        logic [7:0]  byte_3;
        logic [7:0]  byte_4;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  link_mode;
        logic [3:0]  radio_channel;
        logic        channel_changed;
        logic        send_pair_request;
        logic [47:0] peer_address;
        logic        payload_accepted;
        logic        peer_released;
        logic [1:0]  return_cause;
    } out_item_t;

    typedef struct packed {
        logic [15:0] hop_period;
        logic [15:0] req_period;
        logic [15:0] pair_wait;
        logic [15:0] silence_limit;
        logic [3:0]  first_channel;
        logic [3:0]  last_channel;
        logic [7:0]  max_packet_len;
    } cfg_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic        pkt_ok;
        logic        is_hb;
        logic        is_pa;
        logic [47:0] src_mac;
    } cmd_t;

endpackage

// ===== rtl/rlp_front.sv =====
// Front end: accepts input beats and classifies them into commands.
module rlp_front
    import rlp_pkg::*;
(
    input  logic      in_valid,
    output logic      in_stall,
    input  in_item_t  in_data,
    input  logic [7:0] max_packet_len,
    input  logic      q_full,
    output logic      push,
    output cmd_t      cmd
);

    logic ok;
    logic head;

    assign in_stall = q_full;
    assign push     = in_valid && !q_full;

    assign ok   = (in_data.pkt_len != 8'd0) && (in_data.pkt_len <= max_packet_len)
                  && (in_data.byte_0 == CH_BRACE);
    assign head = ok && (in_data.pkt_len >= HEAD_LEN) && (in_data.byte_1 == CH_QUOTE)
                  && (in_data.byte_4 == CH_QUOTE);

    always_comb
    begin
        cmd         = '0;
        cmd.kind    = in_data.action;
        cmd.src_mac = in_data.src_mac;
        cmd.pkt_ok  = ok;
        cmd.is_hb   = head && (in_data.byte_2 == CH_H) && (in_data.byte_3 == CH_B);
        cmd.is_pa   = head && (in_data.byte_2 == CH_P) && (in_data.byte_3 == CH_A);
    end

endmodule

// ===== rtl/rlp_cmd_fifo.sv =====
// Short command queue between the front end and the back end.
module rlp_cmd_fifo
    import rlp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic empty,
    output logic full
);

    cmd_t           mem [QDEPTH];
    logic [QAW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [QAW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [QCW-1:0] count_reg, count_next;

    assign empty   = (count_reg == '0);
    assign full    = (count_reg == QCW'(QDEPTH));
    assign pop_cmd = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == QAW'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== rtl/rlp_back.sv =====
// Back end: mode, channel and timer state; builds the result beat.
module rlp_back
    import rlp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic      clk,
    input  logic      rst_n,
    input  cfg_t      cfg,
    input  logic      q_empty,
    input  cmd_t      cmd,
    output logic      pop,
    output logic      out_valid,
    input  logic      out_stall,
    output out_item_t out_data
);

    localparam int CW = (TIMER_BITS > 16) ? TIMER_BITS : 16;
    localparam logic [TIMER_BITS-1:0] TMAX = '1;

    logic [1:0]            mode_reg, mode_next;
    logic [3:0]            channel_reg, channel_next;
    logic [47:0]           peer_mac_reg, peer_mac_next;
    logic [TIMER_BITS-1:0] hop_reg, hop_next;
    logic [TIMER_BITS-1:0] req_reg, req_next;
    logic [TIMER_BITS-1:0] pair_reg, pair_next;
    logic [TIMER_BITS-1:0] sil_reg, sil_next;
    logic                  out_valid_reg, out_valid_next;
    out_item_t             out_reg, out_next;
    logic [TIMER_BITS-1:0] hop_inc, req_inc, pair_inc, sil_inc;

    assign pop       = !q_empty && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_data  = out_reg;

    assign hop_inc  = (hop_reg == TMAX)  ? hop_reg  : hop_reg + 1'b1;
    assign req_inc  = (req_reg == TMAX)  ? req_reg  : req_reg + 1'b1;
    assign pair_inc = (pair_reg == TMAX) ? pair_reg : pair_reg + 1'b1;
    assign sil_inc  = (sil_reg == TMAX)  ? sil_reg  : sil_reg + 1'b1;

    always_comb
    begin
        mode_next     = mode_reg;
        channel_next  = channel_reg;
        peer_mac_next = peer_mac_reg;
        hop_next      = hop_reg;
        req_next      = req_reg;
        pair_next     = pair_reg;
        sil_next      = sil_reg;
        out_next      = '0;
        if (pop)
        begin
            case (cmd.kind)
                ACT_TICK:
                begin
                    if (mode_reg == MODE_HUNT)
                    begin
                        hop_next = hop_inc;
                        if (CW'(hop_inc) >= CW'(cfg.hop_period))
                        begin
                            hop_next = '0;
                            channel_next = (channel_reg >= cfg.last_channel) ?
                                           cfg.first_channel : channel_reg + 4'd1;
                            out_next.channel_changed = 1'b1;
                        end
                    end
                    else if (mode_reg == MODE_PAIR)
                    begin
                        req_next  = req_inc;
                        pair_next = pair_inc;
                        sil_next  = sil_inc;
                        if (CW'(req_inc) >= CW'(cfg.req_period))
                        begin
                            req_next = '0;
                            out_next.send_pair_request = 1'b1;
                        end
                        if (CW'(pair_inc) > CW'(cfg.pair_wait))
                        begin
                            mode_next = MODE_HUNT;
                            hop_next  = '0;
                            out_next.peer_released = 1'b1;
                            out_next.return_cause  = CAUSE_TIMEOUT;
                        end
                    end
                    else
                    begin
                        sil_next = sil_inc;
                        if (CW'(sil_inc) > CW'(cfg.silence_limit))
                        begin
                            mode_next = MODE_HUNT;
                            hop_next  = '0;
                            out_next.peer_released = 1'b1;
                            out_next.return_cause  = CAUSE_SILENT;
                        end
                    end
                end
                ACT_PKT:
                begin
                    if (cmd.pkt_ok)
                    begin
                        if (mode_reg == MODE_HUNT)
                        begin
                            if (cmd.is_hb)
                            begin
                                peer_mac_next = cmd.src_mac;
                                mode_next     = MODE_PAIR;
                                pair_next     = '0;
                                req_next      = TMAX;
                                sil_next      = '0;
                            end
                        end
                        else if (cmd.src_mac == peer_mac_reg)
                        begin
                            sil_next = '0;
                            if (cmd.is_pa)
                            begin
                                mode_next = MODE_LINK;
                            end
                            else if (!cmd.is_hb && mode_reg == MODE_LINK)
                            begin
                                out_next.payload_accepted = 1'b1;
                            end
                        end
                    end
                end
                ACT_UNPAIR:
                begin
                    mode_next = MODE_HUNT;
                    hop_next  = '0;
                    if (mode_reg != MODE_HUNT)
                    begin
                        out_next.peer_released = 1'b1;
                        out_next.return_cause  = CAUSE_UNPAIR;
                    end
                end
                default:
                begin
                end
            endcase
        end
        out_next.link_mode     = mode_next;
        out_next.radio_channel = channel_next;
        out_next.peer_address  = peer_mac_next;
        out_valid_next = out_valid_reg && out_stall;
        if (pop)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            out_reg <= out_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= MODE_HUNT;
            channel_reg   <= RST_FIRST_CH;
            peer_mac_reg  <= '0;
            hop_reg       <= '0;
            req_reg       <= '0;
            pair_reg      <= '0;
            sil_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            mode_reg      <= mode_next;
            channel_reg   <= channel_next;
            peer_mac_reg  <= peer_mac_next;
            hop_reg       <= hop_next;
            req_reg       <= req_next;
            pair_reg      <= pair_next;
            sil_reg       <= sil_next;
            out_valid_reg <= out_valid_next;
        end
    end

    a_mode_legal: assert property (@(posedge clk) disable iff (!rst_n)
        mode_reg == MODE_HUNT || mode_reg == MODE_PAIR || mode_reg == MODE_LINK)
        else $error("mode register holds an unused code");

    a_release_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.peer_released |->
            out_reg.link_mode == MODE_HUNT && out_reg.return_cause != CAUSE_NONE)
        else $error("release beat without hunt mode or cause");

    a_payload_linked: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.payload_accepted |-> out_reg.link_mode == MODE_LINK)
        else $error("payload flagged outside linked mode");

    a_step_hunt: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_reg.channel_changed |->
            out_reg.link_mode == MODE_HUNT && !out_reg.send_pair_request)
        else $error("channel stepped outside hunt mode");

    a_mode_tracks: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> out_reg.link_mode == mode_reg && out_reg.radio_channel == channel_reg)
        else $error("result beat disagrees with state");

endmodule

// ===== rtl/radio_link_pairing_fsm.sv =====
// Top level of the radio link pairing controller: config registers and front/queue/back.
// An accepted beat is queued, then popped into the output register behind out_valid.
// Throughput: one beat per cycle while out_stall is low; the two-entry command queue and
// the output register let input and output stall independently; in_stall is q_full.
// Reset (rst_n, async, active low): hunting mode, channel 1, peer 0, timers 0,
// config registers at their documented defaults, queue and output empty.
module radio_link_pairing_fsm
    import rlp_pkg::*;
#(
    parameter int TIMER_BITS = TIMER_BITS_DEF
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_wr_en,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  in_item_t               in_data,
    output logic                   out_valid,
    input  logic                   out_stall,
    output out_item_t              out_data
);

    cfg_t cfg_reg;
    logic q_full;
    logic q_empty;
    logic push;
    logic pop;
    cmd_t push_cmd;
    cmd_t pop_cmd;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.hop_period     <= RST_HOP_PERIOD;
            cfg_reg.req_period     <= RST_REQ_PERIOD;
            cfg_reg.pair_wait      <= RST_PAIR_WAIT;
            cfg_reg.silence_limit  <= RST_SILENCE;
            cfg_reg.first_channel  <= RST_FIRST_CH;
            cfg_reg.last_channel   <= RST_LAST_CH;
            cfg_reg.max_packet_len <= RST_MAX_LEN;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_HOP_PERIOD: cfg_reg.hop_period     <= cfg_data;
                REG_REQ_PERIOD: cfg_reg.req_period     <= cfg_data;
                REG_PAIR_WAIT:  cfg_reg.pair_wait      <= cfg_data;
                REG_SILENCE:    cfg_reg.silence_limit  <= cfg_data;
                REG_FIRST_CH:   cfg_reg.first_channel  <= cfg_data[3:0];
                REG_LAST_CH:    cfg_reg.last_channel   <= cfg_data[3:0];
                REG_MAX_LEN:    cfg_reg.max_packet_len <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    rlp_front u_front (
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .in_data        (in_data),
        .max_packet_len (cfg_reg.max_packet_len),
        .q_full         (q_full),
        .push           (push),
        .cmd            (push_cmd)
    );

    rlp_cmd_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .empty    (q_empty),
        .full     (q_full)
    );

    rlp_back #(
        .TIMER_BITS (TIMER_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_empty   (q_empty),
        .cmd       (pop_cmd),
        .pop       (pop),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

endmodule

// ===== dv/tb_radio_link_pairing_fsm.sv =====
// Self-checking testbench for radio_link_pairing_fsm: queued stimulus, beat-level predictor, scoreboard.
`timescale 1ns / 1ps

module tb_radio_link_pairing_fsm;
    import rlp_pkg::*;

    localparam int TW = TIMER_BITS_DEF;
    typedef logic [TW-1:0] tmr_t;

    logic                   clk = 1'b0;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [CFG_INDEX_W-1:0] cfg_index;
    logic [CFG_DATA_W-1:0]  cfg_data;
    logic                   in_valid;
    logic                   in_stall;
    in_item_t               in_data;
    logic                   out_valid;
    logic                   out_stall;
    out_item_t              out_data;

    // predictor state and its copy of the registers
    cfg_t        link_cfg;
    logic [1:0]  st_mode;
    logic [3:0]  st_chan;
    logic [47:0] st_peer;
    tmr_t        hop_ms, req_ms, pair_ms, quiet_ms;

    in_item_t    pending[$];
    out_item_t   expected_out[$];
    out_item_t   want;
    cfg_t        phase_set[7];
    logic [47:0] phase_mac;
    logic [63:0] mac_raw;
    logic [47:0] mac_a, mac_b;
    bit          calm;
    bit          in_fire, out_fire;
    int          in_gap, out_hold;
    int          queued;
    int          fail_count;
    int          beat_no;

    radio_link_pairing_fsm DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_data  (out_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic tmr_t sat_inc(tmr_t v);
        return (v == '1) ? v : v + 1'b1;
    endfunction

    function automatic out_item_t pair_fsm_step(in_item_t it);
        out_item_t r;
        logic      ok, head, is_hb, is_pa;
        r = '0;
        case (it.action)
            ACT_TICK:
            begin
                if (st_mode == MODE_HUNT)
                begin
                    hop_ms = sat_inc(hop_ms);
                    if (hop_ms >= link_cfg.hop_period)
                    begin
                        hop_ms = '0;
                        st_chan = (st_chan >= link_cfg.last_channel) ?
                                  link_cfg.first_channel : st_chan + 4'd1;
                        r.channel_changed = 1'b1;
                    end
                end
                else if (st_mode == MODE_PAIR)
                begin
                    req_ms   = sat_inc(req_ms);
                    pair_ms  = sat_inc(pair_ms);
                    quiet_ms = sat_inc(quiet_ms);
                    if (req_ms >= link_cfg.req_period)
                    begin
                        req_ms = '0;
                        r.send_pair_request = 1'b1;
                    end
                    if (pair_ms > link_cfg.pair_wait)
                    begin
                        st_mode = MODE_HUNT;
                        hop_ms = '0;
                        r.peer_released = 1'b1;
                        r.return_cause = CAUSE_TIMEOUT;
                    end
                end
                else
                begin
                    quiet_ms = sat_inc(quiet_ms);
                    if (quiet_ms > link_cfg.silence_limit)
                    begin
                        st_mode = MODE_HUNT;
                        hop_ms = '0;
                        r.peer_released = 1'b1;
                        r.return_cause = CAUSE_SILENT;
                    end
                end
            end
            ACT_PKT:
            begin
                ok    = (it.pkt_len != 8'd0) && (it.pkt_len <= link_cfg.max_packet_len) &&
                        (it.byte_0 == CH_BRACE);
                head  = ok && (it.pkt_len >= HEAD_LEN) && (it.byte_1 == CH_QUOTE) &&
                        (it.byte_4 == CH_QUOTE);
                is_hb = head && (it.byte_2 == CH_H) && (it.byte_3 == CH_B);
                is_pa = head && (it.byte_2 == CH_P) && (it.byte_3 == CH_A);
                if (ok)
                begin
                    if (st_mode == MODE_HUNT)
                    begin
                        if (is_hb)
                        begin
                            st_peer  = it.src_mac;
                            st_mode  = MODE_PAIR;
                            pair_ms  = '0;
                            req_ms   = '1;
                            quiet_ms = '0;
                        end
                    end
                    else if (it.src_mac == st_peer)
                    begin
                        quiet_ms = '0;
                        if (is_pa)
                            st_mode = MODE_LINK;
                        else if (!is_hb && st_mode == MODE_LINK)
                            r.payload_accepted = 1'b1;
                    end
                end
            end
            ACT_UNPAIR:
            begin
                if (st_mode != MODE_HUNT)
                begin
                    r.peer_released = 1'b1;
                    r.return_cause = CAUSE_UNPAIR;
                end
                st_mode = MODE_HUNT;
                hop_ms = '0;
            end
            default: ;
        endcase
        r.link_mode     = st_mode;
        r.radio_channel = st_chan;
        r.peer_address  = st_peer;
        return r;
    endfunction

    function automatic int draw_wait();
        return calm ? 0 : $urandom_range(0, 18);
    endfunction

    function automatic in_item_t rand_item();
        logic [127:0] raw;
        raw = {$urandom(), $urandom(), $urandom(), $urandom()};
        return raw[$bits(in_item_t)-1:0];
    endfunction

    function automatic in_item_t with_action(logic [1:0] a);
        in_item_t it;
        it = rand_item();
        it.action = a;
        return it;
    endfunction

    function automatic in_item_t mk_pkt(input logic [47:0] mac, input logic [7:0] len,
                                        input logic [7:0] b0, b1, b2, b3, b4);
        in_item_t it;
        it.action  = ACT_PKT;
        it.src_mac = mac;
        it.pkt_len = len;
        it.byte_0  = b0;
        it.byte_1  = b1;
        it.byte_2  = b2;
        it.byte_3  = b3;
        it.byte_4  = b4;
        return it;
    endfunction

    function automatic in_item_t hb(logic [47:0] mac, logic [7:0] len);
        return mk_pkt(mac, len, CH_BRACE, CH_QUOTE, CH_H, CH_B, CH_QUOTE);
    endfunction

    function automatic in_item_t pa(logic [47:0] mac, logic [7:0] len);
        return mk_pkt(mac, len, CH_BRACE, CH_QUOTE, CH_P, CH_A, CH_QUOTE);
    endfunction

    function automatic in_item_t data_pkt(logic [47:0] mac, logic [7:0] len);
        return mk_pkt(mac, len, CH_BRACE, 8'($urandom()), 8'($urandom()),
                      8'($urandom()), 8'($urandom()));
    endfunction

    function automatic logic [7:0] pick_len(int lo);
        if (link_cfg.max_packet_len >= lo && $urandom_range(0, 7) != 0)
            return 8'($urandom_range(lo, link_cfg.max_packet_len));
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [47:0] pick_mac();
        logic [63:0] raw;
        raw = {$urandom(), $urandom()};
        case ($urandom_range(0, 7))
            0:       return '1;
            1:       return '0;
            2:       return raw[47:0];
            default: return phase_mac;
        endcase
    endfunction

    function automatic in_item_t filler(logic [47:0] peer);
        in_item_t    it;
        logic [47:0] other;
        int          k;
        other = peer ^ (48'd1 << $urandom_range(0, 47));
        case ($urandom_range(0, 11))
            0, 1, 2, 3, 4: it = with_action(ACT_TICK);
            5:  it = data_pkt(peer, pick_len(1));
            6:  it = hb(peer, pick_len(int'(HEAD_LEN)));
            7:  it = pa(peer, pick_len(int'(HEAD_LEN)));
            8:  it = ($urandom_range(0, 1) != 0) ? data_pkt(other, pick_len(1)) :
                                                    pa(other, pick_len(int'(HEAD_LEN)));
            9:
            begin
                // accept header with one flipped bit or cut short
                it = pa(peer, pick_len(int'(HEAD_LEN)));
                if ($urandom_range(0, 1) != 0)
                begin
                    k = $urandom_range(0, 31);
                    it[k] = ~it[k];
                end
                else
                    it.pkt_len = 8'($urandom_range(1, 4));
            end
            10: it = rand_item();
            default: it = with_action(($urandom_range(0, 3) == 0) ? ACT_UNPAIR : ACT_NONE);
        endcase
        return it;
    endfunction

    function automatic void push_item(in_item_t it);
        pending.push_back(it);
        queued++;
    endfunction

    task automatic gen_session();
        logic [47:0] peer;
        peer = pick_mac();
        repeat ($urandom_range(0, 6)) push_item(filler(peer));
        push_item(hb(peer, pick_len(int'(HEAD_LEN))));
        repeat ($urandom_range(0, 8)) push_item(filler(peer));
        if ($urandom_range(0, 3) != 0)
        begin
            push_item(pa(peer, pick_len(int'(HEAD_LEN))));
            repeat ($urandom_range(1, 12)) push_item(filler(peer));
        end
        if ($urandom_range(0, 2) == 0)
            repeat ($urandom_range(1, 24)) push_item(with_action(ACT_TICK));
        if ($urandom_range(0, 1) != 0)
            push_item(with_action(ACT_UNPAIR));
    endtask

    task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] exp_val);
        fail_count++;
        if (fail_count <= 100)
            $display("beat %0d %s: got %0h, exp %0h", beat_no, what, got, exp_val);
    endtask

    task automatic wait_drained();
        do
        begin
            @(posedge clk);
            #1;
        end
        while (pending.size() != 0 || in_valid || expected_out.size() != 0);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(negedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        case (idx)
            REG_HOP_PERIOD: link_cfg.hop_period     = val;
            REG_REQ_PERIOD: link_cfg.req_period     = val;
            REG_PAIR_WAIT:  link_cfg.pair_wait      = val;
            REG_SILENCE:    link_cfg.silence_limit  = val;
            REG_FIRST_CH:   link_cfg.first_channel  = val[3:0];
            REG_LAST_CH:    link_cfg.last_channel   = val[3:0];
            REG_MAX_LEN:    link_cfg.max_packet_len = val[7:0];
            default: ;
        endcase
        @(negedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic apply_cfg(cfg_t c);
        wait_drained();
        write_reg(REG_HOP_PERIOD, c.hop_period);
        write_reg(REG_REQ_PERIOD, c.req_period);
        write_reg(REG_PAIR_WAIT,  c.pair_wait);
        write_reg(REG_SILENCE,    c.silence_limit);
        write_reg(REG_FIRST_CH,   {12'd0, c.first_channel});
        write_reg(REG_LAST_CH,    {12'd0, c.last_channel});
        write_reg(REG_MAX_LEN,    {8'd0, c.max_packet_len});
    endtask

    // sample both channels; predict on accepted input beats, score accepted output beats
    always @(posedge clk)
    begin
        in_fire  = rst_n && in_valid && !in_stall;
        out_fire = rst_n && out_valid && !out_stall;
        if (out_fire)
        begin
            if (expected_out.size() == 0)
                report_mismatch("result with nothing expected", 64'(out_data), 64'd0);
            else
            begin
                want = expected_out.pop_front();
                if (out_data.link_mode !== want.link_mode)
                    report_mismatch("link_mode", 64'(out_data.link_mode),
                                    64'(want.link_mode));
                if (out_data.radio_channel !== want.radio_channel)
                    report_mismatch("radio_channel", 64'(out_data.radio_channel),
                                    64'(want.radio_channel));
                if (out_data.channel_changed !== want.channel_changed)
                    report_mismatch("channel_changed", 64'(out_data.channel_changed),
                                    64'(want.channel_changed));
                if (out_data.send_pair_request !== want.send_pair_request)
                    report_mismatch("send_pair_request", 64'(out_data.send_pair_request),
                                    64'(want.send_pair_request));
                if (out_data.peer_address !== want.peer_address)
                    report_mismatch("peer_address", 64'(out_data.peer_address),
                                    64'(want.peer_address));
                if (out_data.payload_accepted !== want.payload_accepted)
                    report_mismatch("payload_accepted", 64'(out_data.payload_accepted),
                                    64'(want.payload_accepted));
                if (out_data.peer_released !== want.peer_released)
                    report_mismatch("peer_released", 64'(out_data.peer_released),
                                    64'(want.peer_released));
                if (out_data.return_cause !== want.return_cause)
                    report_mismatch("return_cause", 64'(out_data.return_cause),
                                    64'(want.return_cause));
            end
            beat_no++;
        end
        if (in_fire)
            expected_out.push_back(pair_fsm_step(in_data));
    end

    // input driver
    always @(negedge clk)
    begin
        if (rst_n && (!in_valid || in_fire))
        begin
            if (in_gap != 0)
            begin
                in_valid <= 1'b0;
                in_gap--;
            end
            else if (pending.size() != 0)
            begin
                in_data  <= pending.pop_front();
                in_valid <= 1'b1;
                in_gap = draw_wait();
            end
            else
                in_valid <= 1'b0;
        end
    end

    // output backpressure
    always @(negedge clk)
    begin
        if (rst_n)
        begin
            if (out_fire)
                out_hold = draw_wait();
            if (out_hold != 0)
            begin
                out_stall <= 1'b1;
                out_hold--;
            end
            else
                out_stall <= 1'b0;
        end
    end

    initial
    begin
        rst_n      = 1'b0;
        cfg_wr_en  = 1'b0;
        cfg_index  = '0;
        cfg_data   = '0;
        in_valid   = 1'b0;
        in_data    = '0;
        out_stall  = 1'b0;
        in_gap     = 0;
        out_hold   = 0;
        fail_count = 0;
        beat_no    = 0;
        calm       = 1'b0;
        link_cfg   = '{RST_HOP_PERIOD, RST_REQ_PERIOD, RST_PAIR_WAIT, RST_SILENCE,
                       RST_FIRST_CH, RST_LAST_CH, RST_MAX_LEN};
        st_mode    = MODE_HUNT;
        st_chan    = RST_FIRST_CH;
        st_peer    = '0;
        hop_ms     = '0;
        req_ms     = '0;
        pair_ms    = '0;
        quiet_ms   = '0;

        phase_set[0] = '{16'd2, 16'd3, 16'd10, 16'd6, 4'd1, 4'd14, 8'd250};
        phase_set[1] = '{16'd1, 16'd1, 16'd1, 16'd1, 4'd14, 4'd14, 8'd5};
        phase_set[2] = '{16'd0, 16'd0, 16'd0, 16'd0, 4'd0, 4'd15, 8'd255};
        phase_set[3] = '{16'd3, 16'd5, 16'd16, 16'd12, 4'd12, 4'd3, 8'd200};
        phase_set[4] = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 4'd1, 4'd14, 8'd250};
        phase_set[5] = '{16'd5, 16'd2, 16'd25, 16'd9, 4'd4, 4'd9, 8'd1};
        phase_set[6] = '{16'd4, 16'd2, 16'd6, 16'd4, 4'd7, 4'd8, 8'd64};

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // directed sequence at reset register values
        mac_a = 48'h0123_4567_89AB;
        mac_b = mac_a ^ 48'd1;
        push_item(with_action(ACT_TICK));
        push_item(hb(mac_a, 8'd0));
        push_item(hb(mac_a, 8'd251));
        push_item(mk_pkt(mac_a, 8'd5, 8'h5B, CH_QUOTE, CH_H, CH_B, CH_QUOTE));
        push_item(hb(mac_a, 8'd4));
        push_item(pa(mac_a, 8'd5));
        push_item(with_action(ACT_UNPAIR));
        push_item(with_action(ACT_NONE));
        push_item(hb(mac_a, 8'd5));
        push_item(with_action(ACT_TICK));
        push_item(data_pkt(mac_a, 8'd20));
        push_item(hb(mac_a, 8'd5));
        push_item(pa(mac_b, 8'd5));
        push_item(pa(mac_a, 8'd250));
        push_item(data_pkt(mac_a, 8'd1));
        push_item(pa(mac_a, 8'd9));
        push_item(hb(mac_a, 8'd9));
        push_item(data_pkt(mac_b, 8'd30));
        push_item(data_pkt(mac_a, 8'd250));
        push_item(with_action(ACT_TICK));
        push_item(with_action(ACT_UNPAIR));
        push_item(hb('1, 8'd255));
        push_item(hb('1, 8'd250));
        push_item(with_action(ACT_NONE));
        push_item(with_action(ACT_UNPAIR));

        for (int p = 0; p < 7; p++)
        begin
            apply_cfg(phase_set[p]);
            calm = (p == 1) || (p == 4);
            mac_raw = {$urandom(), $urandom()};
            phase_mac = mac_raw[47:0];
            queued = 0;
            while (queued < 85)
                gen_session();
        end

        wait_drained();
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

    initial
    begin
        #3_000_000;
        $display("Test completed with failures");
        $finish;
    end

endmodule

// ===== files.f =====
rtl/rlp_pkg.sv
rtl/rlp_front.sv
rtl/rlp_cmd_fifo.sv
rtl/rlp_back.sv
rtl/radio_link_pairing_fsm.sv
dv/tb_radio_link_pairing_fsm.sv
